// ===== hw/rtl/bpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

  // held-tick counter width
  localparam int COUNT_W = 16;
  localparam int DEB_W   = 8;
  localparam int LONG_W  = 16;
  localparam int DATA_W  = 16;
  // compare width that covers both the counter and the limit registers
  localparam int CMP_W   = (COUNT_W > LONG_W) ? COUNT_W : LONG_W;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LONG     = 1'b1;

  localparam logic [DEB_W-1:0]  DEB_RESET  = DEB_W'(20);
  localparam logic [LONG_W-1:0] LONG_RESET = LONG_W'(1000);

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG  = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_DEB_PRESS = 6'b000010,
    PH_HOLD      = 6'b000100,
    PH_DEB_SHORT = 6'b001000,
    PH_WAIT_UP   = 6'b010000,
    PH_DEB_LONG  = 6'b100000
  } bpl_phase_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [LONG_W-1:0] long_ticks;
  } bpl_cfg_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } bpl_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bpl_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpl_cfg_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire                          wr_index,
  input  wire [bpl_pkg::DATA_W-1:0]    wr_data,
  output bpl_pkg::bpl_cfg_t            cfg
);

  logic [bpl_pkg::DEB_W-1:0]  deb_r;
  logic [bpl_pkg::LONG_W-1:0] long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= bpl_pkg::DEB_RESET;
      long_r <= bpl_pkg::LONG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        bpl_pkg::REG_DEBOUNCE: deb_r  <= wr_data[bpl_pkg::DEB_W-1:0];
        bpl_pkg::REG_LONG:     long_r <= wr_data[bpl_pkg::LONG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.debounce_ticks = deb_r;
  assign cfg.long_ticks     = long_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bpl_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpl_fsm (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  wire                 level,
  input  bpl_pkg::bpl_cfg_t   cfg,
  output bpl_pkg::bpl_res_t   res
);

  bpl_pkg::bpl_phase_t phase_r, phase_nxt;
  logic [bpl_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [bpl_pkg::COUNT_W-1:0] count_inc;
  logic [bpl_pkg::CMP_W-1:0]   count_cmp;
  logic                        deb_done;
  logic                        long_done;

  // saturating increment
  assign count_inc = (count_r == '1) ? count_r : count_r + bpl_pkg::COUNT_W'(1);
  assign count_cmp = bpl_pkg::CMP_W'(count_inc);
  assign deb_done  = count_cmp >= bpl_pkg::CMP_W'(cfg.debounce_ticks);
  assign long_done = count_cmp >= bpl_pkg::CMP_W'(cfg.long_ticks);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    res.valid = 1'b0;
    res.kind  = bpl_pkg::KIND_SHORT;
    case (phase_r)
      bpl_pkg::PH_IDLE: begin
        if (!level) begin
          phase_nxt = bpl_pkg::PH_DEB_PRESS;
          count_nxt = '0;
        end
      end
      bpl_pkg::PH_DEB_PRESS: begin
        count_nxt = count_inc;
        if (deb_done) begin
          count_nxt = '0;
          phase_nxt = level ? bpl_pkg::PH_IDLE : bpl_pkg::PH_HOLD;
        end
      end
      bpl_pkg::PH_HOLD: begin
        count_nxt = count_inc;
        if (level) begin
          phase_nxt = bpl_pkg::PH_DEB_SHORT;
          count_nxt = '0;
        end else if (long_done) begin
          phase_nxt = bpl_pkg::PH_WAIT_UP;
          count_nxt = '0;
        end
      end
      bpl_pkg::PH_DEB_SHORT: begin
        count_nxt = count_inc;
        if (deb_done) begin
          count_nxt = '0;
          phase_nxt = bpl_pkg::PH_IDLE;
          res.valid = level;
          res.kind  = bpl_pkg::KIND_SHORT;
        end
      end
      bpl_pkg::PH_WAIT_UP: begin
        if (level) begin
          phase_nxt = bpl_pkg::PH_DEB_LONG;
          count_nxt = '0;
        end
      end
      bpl_pkg::PH_DEB_LONG: begin
        count_nxt = count_inc;
        if (deb_done) begin
          count_nxt = '0;
          phase_nxt = bpl_pkg::PH_IDLE;
          res.valid = 1'b1;
          res.kind  = bpl_pkg::KIND_LONG;
        end
      end
      default: begin
        phase_nxt = bpl_pkg::PH_IDLE;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpl_pkg::PH_IDLE;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  // a long result only comes out of the long release debounce
  a_long_src: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == bpl_pkg::KIND_LONG) |-> (phase_r == bpl_pkg::PH_DEB_LONG))
    else $error("long result outside long debounce");

  // every reported press returns to idle with a cleared counter
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid) |=> (phase_r == bpl_pkg::PH_IDLE && count_r == '0))
    else $error("no return to idle after result");

  // state only moves on a sample beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(phase_r) && $stable(count_r)))
    else $error("state moved without a sample");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/bpl_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpl_out_fifo (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  wire   push_kind,
  output logic  full,
  output logic  out_valid,
  input  wire   out_ready,
  output logic  out_kind
);

  logic       kind_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_kind  = kind_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      kind_r[wr_ptr_r] <= push_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/button_press_length_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready   in_tdata[0]  = button_level (0 pressed)
// out_      out  out_tvalid/out_tready out_tdata[0] = press_kind (0 short, 1 long)
// cfg_      in   cfg_valid/cfg_ready   cfg_index 0 debounce_ticks, 1 long_ticks
//
// one sample beat per cycle: a beat is held in the input register, the state
// machine steps on it, and any result lands in a two-entry output buffer
// the step is held back only when the output buffer is full (sink stalled)
// rst_n is synchronous active low: idle, counter cleared, debounce 20, long 1000
// cfg_ready is always high; writes are expected only while the block is idle

module button_press_length_classifier (
  input  wire                          clk,
  input  wire                          rst_n,
  // sample channel
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [7:0]                   in_tdata,   // [0] button_level, [7:1] zero
  // result channel
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [7:0]                   out_tdata,  // [0] press_kind, [7:1] zero
  // configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire                          cfg_index,
  input  wire  [bpl_pkg::DATA_W-1:0]   cfg_data
);

  bpl_pkg::bpl_cfg_t cfg;
  bpl_pkg::bpl_res_t res;

  // input register
  logic s1_valid_r;
  logic s1_level_r;

  logic fifo_full;
  logic step;
  logic kind;

  assign cfg_ready = 1'b1;

  // the buffered sample is consumed whenever the result buffer has a free slot
  assign step      = s1_valid_r && !fifo_full;
  assign in_tready = !s1_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
    end
  end

  bpl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // press classifier state machine, steps once per sample beat
  bpl_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (s1_level_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result buffer decouples the sink from the sample side
  bpl_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && res.valid),
    .push_kind (res.kind),
    .full      (fifo_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind)
  );

  assign out_tdata = {7'b0, kind};

endmodule

`default_nettype wire

// ===== tb/tb_button_press_length_classifier.sv =====
`timescale 1ns / 1ps

module tb_button_press_length_classifier;

  localparam int HOLD_CYCLES  = 300;   // long sink stall used to back up the input
  localparam int DRAIN_CYCLES = 8;     // input register plus output buffer, with margin
  localparam int TOTAL_BEATS  = 1050;  // queued sample beats at which the random phase stops

  // directed rows: a press of `lows` low samples, then `highs` released samples,
  // then `tail` low samples; a typed outcome lands on the last sample of the row
  typedef enum int {OUT_NONE, OUT_SHORT, OUT_LONG, OUT_MODEL} press_outcome_t;

  typedef struct {
    int             deb;
    int             lng;
    int             lows;
    int             highs;
    int             tail;
    press_outcome_t outcome;
  } press_row_t;

  typedef struct {
    logic level;
    bit   typed;       // expectation comes from the table, not the predictor
    bit   has_result;
    logic kind;
  } sample_beat_t;

  typedef enum int {RX_STREAM, RX_COIN, RX_PATTERN} rx_mode_t;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata   = 8'd0;   // [0] button_level, [7:1] zero
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [7:0]                   out_tdata;           // [0] press_kind, [7:1] zero
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_index  = bpl_pkg::REG_DEBOUNCE;
  logic [bpl_pkg::DATA_W-1:0]   cfg_data   = '0;

  // predictor state and its copy of the registers
  bpl_pkg::bpl_phase_t          press_phase = bpl_pkg::PH_IDLE;
  logic [bpl_pkg::COUNT_W-1:0]  held_count  = '0;
  logic [bpl_pkg::DEB_W-1:0]    deb_cfg     = bpl_pkg::DEB_RESET;
  logic [bpl_pkg::LONG_W-1:0]   long_cfg    = bpl_pkg::LONG_RESET;

  sample_beat_t        sample_q[$];
  logic                expected_kind_q[$];
  sample_beat_t        beat_now;

  int                  burst_left  = 1;
  int                  gap_left    = 0;
  int                  stall_cycles = 0;
  int                  accepted_beats = 0;
  int                  queued_beats = 0;
  int                  errors      = 0;
  int                  short_seen  = 0;
  int                  long_seen   = 0;
  int                  cfg_writes  = 0;

  int                  hold_reqs   = 0;
  int                  hold_served = 0;
  int                  hold_left   = 0;
  int                  rx_cycle    = 0;
  rx_mode_t            rx_mode     = RX_STREAM;
  logic [31:0]         ready_pat   = '1;
  logic                want_kind;
  bit                  fired;
  logic                fired_kind;

  press_row_t dir_rows [16] = '{
    '{20,  1000,  26,  21,  0, OUT_SHORT},  // reset register values
    '{1,   1,     3,   2,   0, OUT_LONG},
    '{1,   1,     2,   2,   0, OUT_SHORT},  // released on the first held tick
    '{1,   1,     1,   1,   0, OUT_NONE},   // failed press debounce
    '{1,   1,     0,   4,   0, OUT_NONE},   // released samples in idle
    '{1,   3,     4,   2,   0, OUT_SHORT},  // one tick under the long limit
    '{1,   3,     5,   2,   0, OUT_LONG},   // exactly the long limit
    '{1,   3,     9,   2,   0, OUT_LONG},   // held past the limit
    '{3,   3,     3,   1,   0, OUT_NONE},   // failed press debounce, longer wait
    '{3,   3,     5,   3,   1, OUT_NONE},   // failed release debounce
    '{3,   3,     7,   1,   3, OUT_LONG},   // long debounce does not resample
    '{0,   0,     3,   2,   0, OUT_LONG},   // zero registers
    '{0,   5,     2,   2,   0, OUT_SHORT},  // zero debounce, short
    '{255, 65535, 266, 256, 0, OUT_SHORT},  // largest registers
    '{2,   1,     4,   3,   0, OUT_LONG},
    '{5,   4,     12,  3,   0, OUT_MODEL}   // stops inside the long debounce
  };

  button_press_length_classifier DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // generous ceiling, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL button_press_length_classifier");
    $finish;
  end

  // one tick of the press classifier
  task automatic step_press_fsm(input logic lvl, output bit got, output logic kind);
    logic [bpl_pkg::CMP_W-1:0] deb_lim;
    logic [bpl_pkg::CMP_W-1:0] long_lim;
    logic [bpl_pkg::CMP_W-1:0] cnt;
    got      = 1'b0;
    kind     = bpl_pkg::KIND_SHORT;
    deb_lim  = bpl_pkg::CMP_W'(deb_cfg);
    long_lim = bpl_pkg::CMP_W'(long_cfg);
    // every phase but idle and wait-for-release counts up, saturating
    if (press_phase != bpl_pkg::PH_IDLE && press_phase != bpl_pkg::PH_WAIT_UP &&
        held_count != '1)
      held_count = held_count + bpl_pkg::COUNT_W'(1);
    cnt = bpl_pkg::CMP_W'(held_count);
    case (press_phase)
      bpl_pkg::PH_IDLE: begin
        if (!lvl) begin
          press_phase = bpl_pkg::PH_DEB_PRESS;
          held_count  = '0;
        end
      end
      bpl_pkg::PH_DEB_PRESS: begin
        if (cnt >= deb_lim) begin
          held_count  = '0;
          press_phase = lvl ? bpl_pkg::PH_IDLE : bpl_pkg::PH_HOLD;
        end
      end
      bpl_pkg::PH_HOLD: begin
        if (lvl) begin
          press_phase = bpl_pkg::PH_DEB_SHORT;
          held_count  = '0;
        end else if (cnt >= long_lim) begin
          press_phase = bpl_pkg::PH_WAIT_UP;
          held_count  = '0;
        end
      end
      bpl_pkg::PH_DEB_SHORT: begin
        if (cnt >= deb_lim) begin
          held_count  = '0;
          press_phase = bpl_pkg::PH_IDLE;
          if (lvl) begin
            got  = 1'b1;
            kind = bpl_pkg::KIND_SHORT;
          end
        end
      end
      bpl_pkg::PH_WAIT_UP: begin
        if (lvl) begin
          press_phase = bpl_pkg::PH_DEB_LONG;
          held_count  = '0;
        end
      end
      bpl_pkg::PH_DEB_LONG: begin
        if (cnt >= deb_lim) begin
          held_count  = '0;
          press_phase = bpl_pkg::PH_IDLE;
          got  = 1'b1;
          kind = bpl_pkg::KIND_LONG;
        end
      end
      default: begin
        press_phase = bpl_pkg::PH_IDLE;
        held_count  = '0;
      end
    endcase
  endtask

  // sample source: bursts of random length with random gaps, runs the
  // predictor on every accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accepted_beats++;
        step_press_fsm(beat_now.level, fired, fired_kind);
        if (beat_now.typed) begin
          if (beat_now.has_result)
            expected_kind_q.push_back(beat_now.kind);
        end else if (fired) begin
          expected_kind_q.push_back(fired_kind);
        end
      end
      if (in_tvalid && !in_tready) begin
        stall_cycles++;   // beat held, keep offering it
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        beat_now = sample_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'd0, beat_now.level};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink: checks every beat, stalls on a pattern of its own, and
  // serves long hold-off requests from the stimulus
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_kind_q.size() == 0) begin
        $error("press_kind: no result expected, actual %0b", out_tdata[0]);
        errors++;
      end else begin
        want_kind = expected_kind_q.pop_front();
        if (out_tdata[0] !== want_kind) begin
          $error("press_kind mismatch: expected %0b, actual %0b", want_kind, out_tdata[0]);
          errors++;
        end
        if (out_tdata[7:1] !== 7'd0) begin
          $error("out_tdata pad mismatch: expected 0, actual %0h", out_tdata[7:1]);
          errors++;
        end
        if (want_kind == bpl_pkg::KIND_LONG)
          long_seen++;
        else
          short_seen++;
      end
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_reqs) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_cycle % 64 == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        ready_pat = $urandom;
      end
      case (rx_mode)
        RX_STREAM: out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        default: begin
          out_tready <= ready_pat[0];
          ready_pat = {ready_pat[0], ready_pat[31:1]};
        end
      endcase
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_tvalid || expected_kind_q.size() != 0)
      @(posedge clk);
  endtask

  // register writes only once the block has nothing left in flight
  task automatic write_reg(input logic idx, input logic [bpl_pkg::DATA_W-1:0] val);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bpl_pkg::REG_DEBOUNCE)
      deb_cfg = val[bpl_pkg::DEB_W-1:0];
    else
      long_cfg = val[bpl_pkg::LONG_W-1:0];
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic queue_level(input logic lvl, input int n, input bit typed);
    repeat (n) sample_q.push_back('{lvl, typed, 1'b0, bpl_pkg::KIND_SHORT});
    queued_beats += n;
  endtask

  // random-level samples, mostly placed where the level does not matter to the press logic
  task automatic queue_bounce(input int n);
    repeat (n) queue_level(1'($urandom_range(0, 1)), 1, 1'b0);
  endtask

  // one press with random timing, mostly well formed
  task automatic queue_press(input int d, input int l);
    int eff_d;
    int kmax;
    eff_d = (d == 0) ? 1 : d;
    queue_level(1'b1, $urandom_range(0, 3), 1'b0);
    queue_level(1'b0, 1, 1'b0);
    queue_bounce(eff_d - 1);
    if ($urandom_range(0, 9) == 0) begin
      queue_level(1'b1, 1, 1'b0);          // press debounce fails
    end else begin
      queue_level(1'b0, 1, 1'b0);
      if (l <= 48 && $urandom_range(0, 1) == 1) begin
        queue_level(1'b0, (l == 0) ? 1 : l, 1'b0);
        queue_level(1'b0, $urandom_range(0, 3), 1'b0);
        queue_level(1'b1, 1, 1'b0);
        queue_bounce(eff_d);
      end else begin
        kmax = (l == 0) ? 0 : ((l - 1 > 40) ? 40 : l - 1);
        queue_level(1'b0, $urandom_range(0, kmax), 1'b0);
        queue_level(1'b1, 1, 1'b0);
        queue_bounce(eff_d - 1);
        // release debounce fails now and then
        queue_level(($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1, 1, 1'b0);
      end
    end
    if ($urandom_range(0, 6) == 0)
      queue_bounce($urandom_range(1, 10));
  endtask

  initial begin
    int rand_stop;
    int presses;
    int d;
    int l;
    int sel;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].deb != int'(deb_cfg))
        write_reg(bpl_pkg::REG_DEBOUNCE, bpl_pkg::DATA_W'(dir_rows[i].deb));
      if (dir_rows[i].lng != int'(long_cfg))
        write_reg(bpl_pkg::REG_LONG, bpl_pkg::DATA_W'(dir_rows[i].lng));
      queue_level(1'b0, dir_rows[i].lows,  dir_rows[i].outcome != OUT_MODEL);
      queue_level(1'b1, dir_rows[i].highs, dir_rows[i].outcome != OUT_MODEL);
      queue_level(1'b0, dir_rows[i].tail,  dir_rows[i].outcome != OUT_MODEL);
      if (dir_rows[i].outcome == OUT_SHORT || dir_rows[i].outcome == OUT_LONG) begin
        sample_q[$].has_result = 1'b1;
        sample_q[$].kind = (dir_rows[i].outcome == OUT_LONG) ? bpl_pkg::KIND_LONG :
                                                               bpl_pkg::KIND_SHORT;
      end
    end

    // back-pressure: fastest presses while the sink holds off for a long stretch
    write_reg(bpl_pkg::REG_DEBOUNCE, bpl_pkg::DATA_W'(1));
    write_reg(bpl_pkg::REG_LONG, bpl_pkg::DATA_W'(1));
    hold_reqs++;
    repeat (24) queue_press(1, 1);

    // random phases, mostly small registers, now and then the extremes
    rand_stop = TOTAL_BEATS;
    while (queued_beats < rand_stop) begin
      sel = $urandom_range(0, 19);
      case (sel)
        0:       begin d = 255;                   l = $urandom_range(1, 3); end
        1:       begin d = 1;                     l = 65535;                end
        2:       begin d = 1;                     l = 1;                    end
        3:       begin d = $urandom_range(7, 30); l = $urandom_range(1, 48); end
        4:       begin d = 0;                     l = $urandom_range(0, 4);  end
        default: begin d = $urandom_range(1, 6);  l = $urandom_range(1, 16); end
      endcase
      write_reg(bpl_pkg::REG_DEBOUNCE, bpl_pkg::DATA_W'(d));
      write_reg(bpl_pkg::REG_LONG, bpl_pkg::DATA_W'(l));
      presses = (d >= 100) ? 1 : $urandom_range(5, 20);
      repeat (presses) queue_press(d, l);
    end

    wait_drained();
    repeat (DRAIN_CYCLES * 3) @(posedge clk);

    $display("run covered %0d sample beats, %0d short and %0d long presses, %0d register writes",
             accepted_beats, short_seen, long_seen, cfg_writes);
    $display("input was held off for %0d cycles by sink back-pressure", stall_cycles);
    if (errors == 0) begin
      $display("PASS button_press_length_classifier");
    end else begin
      $display("FAIL button_press_length_classifier");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bpl_pkg.sv
hw/rtl/bpl_cfg_regs.sv
hw/rtl/bpl_fsm.sv
hw/rtl/bpl_out_fifo.sv
hw/rtl/button_press_length_classifier.sv
tb/tb_button_press_length_classifier.sv
